>>> sv/masked_window_coefficient_of_variation_assert.svh
// Assertion macros for the masked window coefficient of variation block.
// Used by the port checker; no other dependencies.
`ifndef MASKED_WINDOW_COEFFICIENT_OF_VARIATION_ASSERT_SVH
`define MASKED_WINDOW_COEFFICIENT_OF_VARIATION_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MWCV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mwcv assertion failed");

// next-cycle implication
`define MWCV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mwcv assertion failed");

`endif

>>> sv/mwcv_pkg.sv
// Shared types, constants and helper functions for the masked window CV block.
// No dependencies.
package mwcv_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_WIN_DEF     = 15;
    localparam int LANES_DEF       = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int FIELD_W     = 16;
    localparam int CV_W        = 24;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int WIN_REG_W   = 4;
    localparam int LW_REG_W    = 11;
    localparam int LANES_REG_W = 4;
    localparam int EPS_W       = 16;
    localparam int SENT_W      = 16;
    localparam int NUM_LANE_PORTS = 8;

    localparam logic [2:0] REG_WIN_ROWS   = 3'd0;
    localparam logic [2:0] REG_WIN_COLS   = 3'd1;
    localparam logic [2:0] REG_LINE_WIDTH = 3'd2;
    localparam logic [2:0] REG_LANES_USED = 3'd3;
    localparam logic [2:0] REG_EPS        = 3'd4;
    localparam logic [2:0] REG_SENTINEL   = 3'd5;

    localparam logic [WIN_REG_W-1:0]   RST_WIN_ROWS   = 4'd3;
    localparam logic [WIN_REG_W-1:0]   RST_WIN_COLS   = 4'd3;
    localparam logic [LW_REG_W-1:0]    RST_LINE_WIDTH = 11'd1024;
    localparam logic [LANES_REG_W-1:0] RST_LANES_USED = 4'd8;
    localparam logic [EPS_W-1:0]       RST_EPS        = 16'd1;
    localparam logic [SENT_W-1:0]      RST_SENTINEL   = 16'hFFFF;

    localparam logic [CV_W-1:0] CV_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        T_IDLE, T_SCAN, T_DRAIN, T_LANE, T_MERGE, T_OUT
    } t_top_state;

    typedef enum logic [1:0] {
        L_IDLE, L_DIV, L_SQ, L_VAR
    } t_lane_state;

    typedef enum logic [2:0] {
        M_IDLE, M_SUM, M_DIVL, M_SQRT, M_CSTART, M_DIVC
    } t_merge_state;

    typedef struct packed {
        logic clear;
        logic acc_en;
        logic start;
    } t_lane_ctl;

    function automatic int mean_w(int sb);
        return (sb > SENT_W) ? sb : SENT_W;
    endfunction

    function automatic int var_w(int sb);
        return (2 * sb > SENT_W + 8) ? 2 * sb : SENT_W + 8;
    endfunction

    function automatic int cnt_w(int max_win);
        return $clog2(max_win * max_win + 1);
    endfunction

    // zero -> 1, clamp to max, round even down to odd
    function automatic int eff_win(int w, int max_win);
        int t;
        t = w;
        if (t == 0) t = 1;
        if (t > max_win) t = max_win;
        if ((t & 1) == 0) t = t - 1;
        return t;
    endfunction

    function automatic int eff_clamp(int v, int max_v);
        int t;
        t = v;
        if (t == 0) t = 1;
        if (t > max_v) t = max_v;
        return t;
    endfunction

endpackage

>>> sv/mwcv_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mwcv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/mwcv_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
module mwcv_div #(
    parameter int NW = 32,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_q;
    logic [DW-1:0]    r_r;
    logic [DW-1:0]    r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             take;

    always_comb begin
        rem_sh = {r_r, r_q[NW-1]};
        diff   = rem_sh - {1'b0, r_d};
        take   = (rem_sh >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[NW-2:0], take};
            r_r <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> sv/mwcv_lane.sv
// One lane: masked window sums of value, square and count, then mean and variance.
// Depends on mwcv_pkg and mwcv_div.
module mwcv_lane #(
    parameter int SB      = mwcv_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_WIN = mwcv_pkg::MAX_WIN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mwcv_pkg::t_lane_ctl              i_ctl,
    input  logic [SB-1:0]                    i_x,
    input  logic                             i_xv,
    input  logic [mwcv_pkg::SENT_W-1:0]      i_sent,
    output logic [mwcv_pkg::mean_w(SB)-1:0]  o_m,
    output logic [mwcv_pkg::var_w(SB)-1:0]   o_v,
    output logic                             o_done
);
    import mwcv_pkg::*;

    localparam int CW  = cnt_w(MAX_WIN);
    localparam int S_W = SB + CW;
    localparam int Q_W = 2 * SB + CW;
    localparam int MW  = mean_w(SB);
    localparam int VW  = var_w(SB);

    t_lane_state r_state, n_state;

    logic [SB-1:0]     r_x1;
    logic [2*SB-1:0]   r_sq1;
    logic              r_e1;
    logic [S_W-1:0]    r_s;
    logic [Q_W-1:0]    r_qs;
    logic [CW-1:0]     r_cnt;
    logic [MW-1:0]     r_m;
    logic [VW-1:0]     r_qm;
    logic [2*MW-1:0]   r_mm;
    logic [VW-1:0]     r_v;
    logic              r_done;
    logic              s_done;
    logic              q_done;
    logic [S_W-1:0]    s_quot;
    logic [Q_W-1:0]    q_quot;
    logic [2*MW-1:0]   qm_ext;

    mwcv_div #(.NW(S_W), .DW(CW)) u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_ctl.start),
        .i_num(r_s), .i_den(r_cnt), .o_done(s_done), .o_quot(s_quot)
    );

    mwcv_div #(.NW(Q_W), .DW(CW)) u_div_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_ctl.start),
        .i_num(r_qs), .i_den(r_cnt), .o_done(q_done), .o_quot(q_quot)
    );

    assign qm_ext = (2 * MW)'(r_qm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_e1    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_e1    <= i_ctl.acc_en & i_xv;
            r_done  <= (r_state == L_VAR);
        end
    end

    // the square sum divide is the longer one; the value divide is done by then
    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE:  if (i_ctl.start) n_state = L_DIV;
            L_DIV:   if (q_done) n_state = L_SQ;
            L_SQ:    n_state = L_VAR;
            L_VAR:   n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x1  <= i_x;
        r_sq1 <= i_x * i_x;
        if (i_ctl.clear) begin
            r_s   <= '0;
            r_qs  <= '0;
            r_cnt <= '0;
        end else if (r_e1) begin
            r_s   <= r_s + S_W'(r_x1);
            r_qs  <= r_qs + Q_W'(r_sq1);
            r_cnt <= r_cnt + CW'(1);
        end
        if (r_state == L_DIV && q_done) begin
            r_m  <= (r_cnt != '0) ? MW'(s_quot) : MW'(i_sent);
            r_qm <= VW'(q_quot);
        end
        if (r_state == L_SQ) r_mm <= r_m * r_m;
        if (r_state == L_VAR) begin
            if (r_cnt == '0) r_v <= VW'(i_sent) << 8;
            else if (qm_ext >= r_mm) r_v <= VW'(qm_ext - r_mm);
            else r_v <= '0;
        end
    end

    assign o_m    = r_m;
    assign o_v    = r_v;
    assign o_done = r_done & ~s_done;
endmodule

>>> sv/mwcv_merge.sv
// Merging stage: lane averages, serial square root and final divide with saturation.
// Depends on mwcv_pkg and mwcv_div.
module mwcv_merge #(
    parameter int LANES = mwcv_pkg::LANES_DEF,
    parameter int SB    = mwcv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [mwcv_pkg::LANES_REG_W-1:0]     i_lanes,
    input  logic [mwcv_pkg::EPS_W-1:0]           i_eps,
    input  logic [mwcv_pkg::mean_w(SB)-1:0]      i_m [LANES],
    input  logic [mwcv_pkg::var_w(SB)-1:0]       i_v [LANES],
    output logic [mwcv_pkg::CV_W-1:0]            o_cv,
    output logic                                 o_done
);
    import mwcv_pkg::*;

    localparam int MW    = mean_w(SB);
    localparam int VW    = var_w(SB);
    localparam int MS_W  = MW + 3;
    localparam int VS_W  = VW + 3;
    localparam int XW    = VW + 16;
    localparam int RW    = XW / 2;
    localparam int NUM_W = RW + 8;
    localparam int DEN_W = ((MW > EPS_W) ? MW : EPS_W) + 1;
    localparam int K_W   = $clog2(RW + 1);

    t_merge_state r_state, n_state;

    logic [MS_W-1:0]  msum;
    logic [VS_W-1:0]  vsum;
    logic [MS_W-1:0]  r_msum;
    logic [VS_W-1:0]  r_vsum;
    logic [MW-1:0]    r_mavg;
    logic [XW-1:0]    r_x;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [K_W-1:0]   r_k;
    logic [CV_W-1:0]  r_cv;
    logic             r_done;
    logic             divl_start;
    logic             divc_start;
    logic             dm_done;
    logic             dv_done;
    logic             dc_done;
    logic [MS_W-1:0]  dm_quot;
    logic [VS_W-1:0]  dv_quot;
    logic [NUM_W-1:0] dc_quot;
    logic [RW+3:0]    rem_n;
    logic [RW+3:0]    trial;
    logic [RW+3:0]    rem_d;
    logic             take;
    logic [DEN_W-1:0] den;

    always_comb begin
        msum = '0;
        vsum = '0;
        for (int l = 0; l < LANES; l++) begin
            if (LANES_REG_W'(l) < i_lanes) begin
                msum = msum + MS_W'(i_m[l]);
                vsum = vsum + VS_W'(i_v[l]);
            end
        end
    end

    mwcv_div #(.NW(MS_W), .DW(LANES_REG_W)) u_div_m (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(divl_start),
        .i_num(r_msum), .i_den(i_lanes), .o_done(dm_done), .o_quot(dm_quot)
    );

    mwcv_div #(.NW(VS_W), .DW(LANES_REG_W)) u_div_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(divl_start),
        .i_num(r_vsum), .i_den(i_lanes), .o_done(dv_done), .o_quot(dv_quot)
    );

    assign den = DEN_W'(r_mavg) + DEN_W'(i_eps);

    mwcv_div #(.NW(NUM_W), .DW(DEN_W)) u_div_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(divc_start),
        .i_num({r_root, 8'd0}), .i_den(den), .o_done(dc_done), .o_quot(dc_quot)
    );

    // two radicand bits per step
    always_comb begin
        rem_n = {r_rem, r_x[XW-1 -: 2]};
        trial = {2'b00, r_root, 2'b01};
        take  = (rem_n >= trial);
        rem_d = rem_n - trial;
    end

    always_comb begin
        n_state    = r_state;
        divl_start = 1'b0;
        divc_start = 1'b0;
        case (r_state)
            M_IDLE:   if (i_start) n_state = M_SUM;
            M_SUM: begin
                divl_start = 1'b1;
                n_state    = M_DIVL;
            end
            M_DIVL:   if (dv_done) n_state = M_SQRT;
            M_SQRT:   if (r_k == K_W'(1)) n_state = M_CSTART;
            M_CSTART: begin
                divc_start = 1'b1;
                n_state    = M_DIVC;
            end
            M_DIVC:   if (dc_done) n_state = M_IDLE;
            default:  n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_DIVC) && dc_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) begin
            r_msum <= msum;
            r_vsum <= vsum;
        end
        // the mean divide is the shorter one and finishes first
        if (r_state == M_DIVL && dm_done) r_mavg <= MW'(dm_quot);
        if (r_state == M_DIVL && dv_done) begin
            r_x    <= {VW'(dv_quot), 16'd0};
            r_rem  <= '0;
            r_root <= '0;
            r_k    <= K_W'(RW);
        end
        if (r_state == M_SQRT) begin
            r_rem  <= take ? rem_d[RW+1:0] : rem_n[RW+1:0];
            r_root <= {r_root[RW-2:0], take};
            r_x    <= r_x << 2;
            r_k    <= r_k - K_W'(1);
        end
        if (r_state == M_DIVC && dc_done) begin
            if (den == '0) r_cv <= (r_root != '0) ? CV_MAX : '0;
            else if (dc_quot > NUM_W'(CV_MAX)) r_cv <= CV_MAX;
            else r_cv <= CV_W'(dc_quot);
        end
    end

    assign o_cv   = r_cv;
    assign o_done = r_done;
endmodule

>>> sv/masked_window_coefficient_of_variation.sv
// Top level of the masked window coefficient of variation block.
// Depends on mwcv_pkg, mwcv_ram, mwcv_lane and mwcv_merge.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_sample_0..7, i_pixel_valid
//  out     | output    | o_out_valid / i_out_ready    | o_cv_value, o_centre_valid, o_row_last
//  cfg     | input     | APB psel/penable/pwrite      | paddr, pwdata, prdata (pready tied)
//
// A transaction that completes no window leaves the block ready. One that completes
// a window holds the input off through the window read loop over the line store
// port and through the bit-serial dividers and square root.
// Reset is synchronous, active low; line stores are not cleared.
// A finished result waits in the output register; the next input transaction is
// taken meanwhile, and the block only stalls once a second result is ready.
module masked_window_coefficient_of_variation #(
    parameter int MAX_WIDTH   = mwcv_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WIN     = mwcv_pkg::MAX_WIN_DEF,
    parameter int LANES       = mwcv_pkg::LANES_DEF,
    parameter int SAMPLE_BITS = mwcv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mwcv_pkg::PADDR_W-1:0]   paddr,
    input  logic [mwcv_pkg::PDATA_W-1:0]   pwdata,
    output logic [mwcv_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mwcv_pkg::FIELD_W-1:0]   i_sample_0,
    input  logic [mwcv_pkg::FIELD_W-1:0]   i_sample_1,
    input  logic [mwcv_pkg::FIELD_W-1:0]   i_sample_2,
    input  logic [mwcv_pkg::FIELD_W-1:0]   i_sample_3,
    input  logic [mwcv_pkg::FIELD_W-1:0]   i_sample_4,
    input  logic [mwcv_pkg::FIELD_W-1:0]   i_sample_5,
    input  logic [mwcv_pkg::FIELD_W-1:0]   i_sample_6,
    input  logic [mwcv_pkg::FIELD_W-1:0]   i_sample_7,
    input  logic                           i_pixel_valid,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mwcv_pkg::CV_W-1:0]      o_cv_value,
    output logic                           o_centre_valid,
    output logic                           o_row_last
);
    import mwcv_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int MW     = mean_w(SB);
    localparam int VW     = var_w(SB);
    localparam int DEPTH  = MAX_WIN * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int LW_W   = $clog2(MAX_WIDTH + 1);
    localparam int WIN_W  = $clog2(MAX_WIN + 1);
    localparam int RING_W = $clog2(MAX_WIN);
    localparam int P_W    = ((LW_W > WIN_W) ? LW_W : WIN_W) + 1;

    // ---------------- configuration registers ----------------
    logic [WIN_REG_W-1:0]   r_win_rows;
    logic [WIN_REG_W-1:0]   r_win_cols;
    logic [LW_REG_W-1:0]    r_line_width;
    logic [LANES_REG_W-1:0] r_lanes_used;
    logic [EPS_W-1:0]       r_eps;
    logic [SENT_W-1:0]      r_sent;
    logic                   cfg_we;
    logic [2:0]             cfg_idx;
    logic                   cfg_hit;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];
    assign cfg_hit = cfg_we && (cfg_idx == REG_WIN_ROWS || cfg_idx == REG_WIN_COLS ||
                                cfg_idx == REG_LINE_WIDTH || cfg_idx == REG_LANES_USED ||
                                cfg_idx == REG_EPS || cfg_idx == REG_SENTINEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_rows   <= RST_WIN_ROWS;
            r_win_cols   <= RST_WIN_COLS;
            r_line_width <= RST_LINE_WIDTH;
            r_lanes_used <= RST_LANES_USED;
            r_eps        <= RST_EPS;
            r_sent       <= RST_SENTINEL;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_WIN_ROWS:   r_win_rows   <= pwdata[WIN_REG_W-1:0];
                REG_WIN_COLS:   r_win_cols   <= pwdata[WIN_REG_W-1:0];
                REG_LINE_WIDTH: r_line_width <= pwdata[LW_REG_W-1:0];
                REG_LANES_USED: r_lanes_used <= pwdata[LANES_REG_W-1:0];
                REG_EPS:        r_eps        <= pwdata[EPS_W-1:0];
                REG_SENTINEL:   r_sent       <= pwdata[SENT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIN_ROWS:   prdata = PDATA_W'(r_win_rows);
            REG_WIN_COLS:   prdata = PDATA_W'(r_win_cols);
            REG_LINE_WIDTH: prdata = PDATA_W'(r_line_width);
            REG_LANES_USED: prdata = PDATA_W'(r_lanes_used);
            REG_EPS:        prdata = PDATA_W'(r_eps);
            REG_SENTINEL:   prdata = PDATA_W'(r_sent);
            default:        prdata = '0;
        endcase
    end

    // effective sizes: odd windows, clamped width and lane count
    logic [WIN_W-1:0]       wr;
    logic [WIN_W-1:0]       wc;
    logic [LW_W-1:0]        lw;
    logic [LANES_REG_W-1:0] lanes_eff;

    assign wr        = WIN_W'(eff_win(int'(r_win_rows), MAX_WIN));
    assign wc        = WIN_W'(eff_win(int'(r_win_cols), MAX_WIN));
    assign lw        = LW_W'(eff_clamp(int'(r_line_width), MAX_WIDTH));
    assign lanes_eff = LANES_REG_W'(eff_clamp(int'(r_lanes_used), LANES));

    // ---------------- raster position ----------------
    logic [COL_W-1:0]  r_col;
    logic [15:0]       r_row;
    logic [RING_W-1:0] r_head;
    logic [COL_W-1:0]  col;
    logic              due;
    logic              line_end;
    logic              in_acc;

    assign col      = (LW_W'(r_col) >= lw) ? '0 : r_col;
    assign line_end = (P_W'(col) + P_W'(1) >= P_W'(lw));
    assign due      = (17'(r_row) + 17'd1 >= 17'(wr)) && (P_W'(col) + P_W'(1) >= P_W'(wc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col  <= '0;
            r_row  <= '0;
            r_head <= '0;
        end else if (in_acc) begin
            if (line_end) begin
                r_col  <= '0;
                r_head <= (r_head == RING_W'(MAX_WIN - 1)) ? '0 : r_head + RING_W'(1);
                if (r_row != 16'hFFFF) r_row <= r_row + 16'd1;
            end else begin
                r_col <= col + COL_W'(1);
            end
        end
    end

    // ---------------- line stores, one sample RAM per lane ----------------
    logic [FIELD_W-1:0] in_s [NUM_LANE_PORTS];
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic               re;
    logic [SB-1:0]      s_rdata [LANES];
    logic               v_rdata;

    assign in_s[0] = i_sample_0;
    assign in_s[1] = i_sample_1;
    assign in_s[2] = i_sample_2;
    assign in_s[3] = i_sample_3;
    assign in_s[4] = i_sample_4;
    assign in_s[5] = i_sample_5;
    assign in_s[6] = i_sample_6;
    assign in_s[7] = i_sample_7;

    assign waddr = ADDR_W'(r_head) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);

    mwcv_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_valid_ram (
        .i_clk(i_clk), .i_we(in_acc), .i_waddr(waddr), .i_wdata(i_pixel_valid),
        .i_re(re), .i_raddr(raddr), .o_rdata(v_rdata)
    );

    // ---------------- sequencer ----------------
    t_top_state        r_state, n_state;
    logic [RING_W-1:0] r_slot;
    logic [COL_W-1:0]  r_cc;
    logic [COL_W-1:0]  r_scol;
    logic [COL_W-1:0]  r_cstart;
    logic [WIN_W-1:0]  r_rows_left;
    logic [RING_W-1:0] r_cslot;
    logic [COL_W-1:0]  r_ccol;
    logic              r_ph_centre;
    logic              r_rk_ctr;
    logic              r_rk_win;
    logic [1:0]        r_dcnt;
    logic              r_cvalid;
    logic              r_rl;
    logic              r_ov;
    logic [CV_W-1:0]   r_ocv;
    logic              r_ocvd;
    logic              r_orl;
    logic              win_last;
    logic              load_out;
    logic              merge_start;
    logic              merge_done;
    logic [CV_W-1:0]   merge_cv;
    logic [LANES-1:0]  lane_done;
    t_lane_ctl         lane_ctl;
    logic [RING_W-1:0] half_r;
    logic [RING_W-1:0] cslot;

    assign o_in_ready = (r_state == T_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign win_last   = (r_cc == r_scol) && (r_rows_left == WIN_W'(1));
    assign raddr      = r_ph_centre ? ADDR_W'(r_cslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_ccol)
                                    : ADDR_W'(r_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_cc);

    // centre row lies wr/2 lines behind the head, wrapping round the ring
    assign half_r = RING_W'(wr >> 1);
    assign cslot  = (r_head >= half_r) ? r_head - half_r
                                       : r_head + RING_W'(MAX_WIN) - half_r;

    always_comb begin
        n_state        = r_state;
        re             = 1'b0;
        load_out       = 1'b0;
        merge_start    = 1'b0;
        lane_ctl.clear = in_acc & due;
        lane_ctl.acc_en = r_rk_win;
        lane_ctl.start = 1'b0;
        case (r_state)
            T_IDLE:  if (in_acc && due) n_state = T_SCAN;
            T_SCAN: begin
                re = 1'b1;
                if (!r_ph_centre && win_last) n_state = T_DRAIN;
            end
            T_DRAIN: begin
                // last read plus two lane accumulate stages
                if (r_dcnt == 2'd2) begin
                    lane_ctl.start = 1'b1;
                    n_state        = T_LANE;
                end
            end
            T_LANE: begin
                if (&lane_done) begin
                    merge_start = 1'b1;
                    n_state     = T_MERGE;
                end
            end
            T_MERGE: if (merge_done) n_state = T_OUT;
            T_OUT: begin
                if (!r_ov || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_rk_ctr    <= 1'b0;
            r_rk_win    <= 1'b0;
            r_ph_centre <= 1'b0;
            r_dcnt      <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rk_ctr <= (r_state == T_SCAN) && r_ph_centre;
            r_rk_win <= (r_state == T_SCAN) && !r_ph_centre;
            if (in_acc && due) r_ph_centre <= 1'b1;
            else if (r_state == T_SCAN) r_ph_centre <= 1'b0;
            r_dcnt <= (r_state == T_DRAIN) ? r_dcnt + 2'd1 : 2'd0;
            if (load_out) r_ov <= 1'b1;
            else if (o_out_valid && i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && due) begin
            r_scol      <= col;
            r_cstart    <= col + COL_W'(1) - COL_W'(wc);
            r_cc        <= col + COL_W'(1) - COL_W'(wc);
            r_slot      <= r_head;
            r_rows_left <= wr;
            r_cslot     <= cslot;
            r_ccol      <= col - COL_W'(wc >> 1);
            r_rl        <= line_end;
        end else if (r_state == T_SCAN && !r_ph_centre) begin
            if (r_cc == r_scol) begin
                r_cc        <= r_cstart;
                r_slot      <= (r_slot == '0) ? RING_W'(MAX_WIN - 1) : r_slot - RING_W'(1);
                r_rows_left <= r_rows_left - WIN_W'(1);
            end else begin
                r_cc <= r_cc + COL_W'(1);
            end
        end
        if (r_rk_ctr) r_cvalid <= v_rdata;
        if (load_out) begin
            r_ocv  <= r_cvalid ? merge_cv : '0;
            r_ocvd <= r_cvalid;
            r_orl  <= r_rl;
        end
    end

    // ---------------- lanes and merge ----------------
    logic [MW-1:0] lane_m [LANES];
    logic [VW-1:0] lane_v [LANES];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mwcv_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_sample_ram (
            .i_clk(i_clk), .i_we(in_acc), .i_waddr(waddr), .i_wdata(SB'(in_s[g])),
            .i_re(re), .i_raddr(raddr), .o_rdata(s_rdata[g])
        );

        mwcv_lane #(.SB(SB), .MAX_WIN(MAX_WIN)) u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl),
            .i_x(s_rdata[g]), .i_xv(v_rdata), .i_sent(r_sent),
            .o_m(lane_m[g]), .o_v(lane_v[g]), .o_done(lane_done[g])
        );
    end

    mwcv_merge #(.LANES(LANES), .SB(SB)) u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(merge_start),
        .i_lanes(lanes_eff), .i_eps(r_eps), .i_m(lane_m), .i_v(lane_v),
        .o_cv(merge_cv), .o_done(merge_done)
    );

    assign o_out_valid    = r_ov;
    assign o_cv_value     = r_ocv;
    assign o_centre_valid = r_ocvd;
    assign o_row_last     = r_orl;
endmodule

>>> sv/mwcv_checker.sv
// Port-level checker for the masked window CV block, bound to the top level.
// Depends on masked_window_coefficient_of_variation_assert.svh.
`include "masked_window_coefficient_of_variation_assert.svh"

module mwcv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_cv_value,
    input logic        o_centre_valid,
    input logic        o_row_last
);
    `MWCV_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `MWCV_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_cv_value) && $stable(o_centre_valid) && $stable(o_row_last))
    `MWCV_ASSERT_IMP(a_invalid_centre_zero, o_out_valid && !o_centre_valid, o_cv_value == 24'd0)
    `MWCV_ASSERT_IMP(a_pready_high, 1'b1, pready)
endmodule

bind masked_window_coefficient_of_variation mwcv_checker u_mwcv_checker (.*);

>>> bench/masked_window_coefficient_of_variation_tb.sv
// Self-checking bench for masked_window_coefficient_of_variation: random and directed
// pixels, APB register writes, its own window CV predictor. Depends on mwcv_pkg.
module masked_window_coefficient_of_variation_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mwcv_pkg::*;

    localparam int WIN_MAX  = 15;
    localparam int LINE_MAX = 1024;
    localparam int NLANE    = 8;
    localparam int DRAIN    = 600;    // well above the worst result latency

    typedef struct packed {
        logic [7:0][15:0] smp;
        logic             pv;
    } pixel_t;

    typedef struct packed {
        logic [23:0] cv;
        logic        cvalid;
        logic        rlast;
    } cv_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [15:0] i_sample_0 = '0, i_sample_1 = '0, i_sample_2 = '0, i_sample_3 = '0;
    logic [15:0] i_sample_4 = '0, i_sample_5 = '0, i_sample_6 = '0, i_sample_7 = '0;
    logic i_pixel_valid = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [CV_W-1:0] o_cv_value;
    logic o_centre_valid, o_row_last;

    masked_window_coefficient_of_variation dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

    // predictor state: registers, line stores, raster position
    int unsigned cfg_reg [0:5];
    logic [15:0] sample_mem [0:WIN_MAX-1][0:LINE_MAX-1][0:NLANE-1];
    bit          valid_mem  [0:WIN_MAX-1][0:LINE_MAX-1];
    int unsigned col_pos, row_pos, ring_head;

    pixel_t     pending_pixels[$];
    cv_result_t cv_expected[$];
    int         fails = 0;
    int         send_idle_pct = 0, recv_idle_pct = 0;
    bit         long_hold_req = 0;

    function automatic int unsigned odd_window(int unsigned w);
        int unsigned t;
        t = (w == 0) ? 1 : w;
        if (t > WIN_MAX) t = WIN_MAX;
        return (t % 2 == 0) ? t - 1 : t;
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r, trial;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x) r = trial;
        end
        return r;
    endfunction

    // one accepted pixel: store it, and queue a CV result if it closes a window
    function automatic void predict_cv(pixel_t px);
        int unsigned wr, wc, lw, nl, col, head, cslot, ccol, slot;
        longint unsigned msum, vsum, s, q, cnt, m, v, x, big_m, big_v, num, den, cv;
        cv_result_t res;
        wr = odd_window(cfg_reg[REG_WIN_ROWS]);
        wc = odd_window(cfg_reg[REG_WIN_COLS]);
        lw = cfg_reg[REG_LINE_WIDTH];
        if (lw == 0) lw = 1;
        if (lw > LINE_MAX) lw = LINE_MAX;
        nl = cfg_reg[REG_LANES_USED];
        if (nl == 0) nl = 1;
        if (nl > NLANE) nl = NLANE;
        col = (col_pos >= lw) ? 0 : col_pos;
        head = ring_head;
        for (int l = 0; l < NLANE; l++) sample_mem[head][col][l] = px.smp[l];
        valid_mem[head][col] = px.pv;

        if (row_pos + 1 >= wr && col + 1 >= wc) begin
            msum = 0;
            vsum = 0;
            cslot = (head + WIN_MAX - wr / 2) % WIN_MAX;
            ccol = col - wc / 2;
            for (int l = 0; l < nl; l++) begin
                s = 0; q = 0; cnt = 0;
                for (int rr = 0; rr < wr; rr++) begin
                    slot = (head + WIN_MAX - rr) % WIN_MAX;
                    for (int cc = col + 1 - wc; cc <= col; cc++) begin
                        if (valid_mem[slot][cc]) begin
                            x = sample_mem[slot][cc][l];
                            s += x;
                            q += x * x;
                            cnt++;
                        end
                    end
                end
                if (cnt != 0) begin
                    m = s / cnt;
                    v = (q / cnt >= m * m) ? q / cnt - m * m : 0;
                end else begin
                    m = cfg_reg[REG_SENTINEL];   // empty window stand-in
                    v = longint'(cfg_reg[REG_SENTINEL]) << 8;
                end
                msum += m;
                vsum += v;
            end
            big_m = msum / nl;
            big_v = vsum / nl;
            cv = 0;
            res.cvalid = valid_mem[cslot][ccol];
            if (res.cvalid) begin
                num = int_root(big_v << 16) << 8;
                den = big_m + cfg_reg[REG_EPS];
                if (den == 0) cv = (num != 0) ? 64'hFFFFFF : 0;
                else cv = num / den;
                if (cv > 64'hFFFFFF) cv = 64'hFFFFFF;
            end
            res.cv = cv[23:0];
            res.rlast = (col + 1 == lw);
            cv_expected.push_back(res);
        end

        if (col + 1 >= lw) begin
            col_pos = 0;
            ring_head = (head + 1) % WIN_MAX;
            if (row_pos < 16'hFFFF) row_pos++;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    // driver: feeds pending pixels, predicts on each accepted transaction
    always @(posedge i_clk) begin : drive_pixels
        pixel_t px;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict_cv({i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                            i_sample_3, i_sample_2, i_sample_1, i_sample_0, i_pixel_valid});
            if (!i_in_valid || o_in_ready) begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    px = pending_pixels.pop_front();
                    {i_sample_7, i_sample_6, i_sample_5, i_sample_4} <= px.smp[7:4];
                    {i_sample_3, i_sample_2, i_sample_1, i_sample_0} <= px.smp[3:0];
                    i_pixel_valid <= px.pv;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    always @(posedge i_clk) begin : drive_ready
        int hold_cnt;
        if (long_hold_req && hold_cnt == 0) hold_cnt = 3000;
        if (hold_cnt > 0) begin
            hold_cnt--;
            if (hold_cnt == 0) long_hold_req = 0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        cv_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cv_expected.size() == 0) begin
                $display("%0t: unexpected result cv=%h cvalid=%b last=%b",
                         $time, o_cv_value, o_centre_valid, o_row_last);
                fails++;
            end else begin
                want = cv_expected.pop_front();
                if (o_cv_value !== want.cv) begin
                    $display("%0t: cv_value expected %h got %h", $time, want.cv, o_cv_value);
                    fails++;
                end
                if (o_centre_valid !== want.cvalid) begin
                    $display("%0t: centre_valid expected %b got %b",
                             $time, want.cvalid, o_centre_valid);
                    fails++;
                end
                if (o_row_last !== want.rlast) begin
                    $display("%0t: row_last expected %b got %b",
                             $time, want.rlast, o_row_last);
                    fails++;
                end
            end
        end
    end

    // APB write: setup then access; predictor copy is updated at the write edge
    task automatic reg_write(int idx, int unsigned value);
        int unsigned wmask [0:5];
        wmask = '{32'hF, 32'hF, 32'h7FF, 32'hF, 32'hFFFF, 32'hFFFF};
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx < 6) begin
            cfg_reg[idx] = value & wmask[idx];
            col_pos = 0;
            row_pos = 0;
            ring_head = 0;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(int unsigned wr, int unsigned wc, int unsigned lw,
                              int unsigned nl, int unsigned eps, int unsigned sent);
        reg_write(REG_WIN_ROWS, wr);
        reg_write(REG_WIN_COLS, wc);
        reg_write(REG_LINE_WIDTH, lw);
        reg_write(REG_LANES_USED, nl);
        reg_write(REG_EPS, eps);
        reg_write(REG_SENTINEL, sent);
    endtask

    // wait until every pixel is in and every result out, then let the block settle
    task automatic drain_block();
        while (pending_pixels.size() != 0 || i_in_valid || cv_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic pixel_t random_pixel();
        pixel_t px;
        int kind;
        kind = $urandom_range(9);
        for (int l = 0; l < NLANE; l++) begin
            if (kind < 5)      px.smp[l] = $urandom;
            else if (kind < 8) px.smp[l] = $urandom_range(7);
            else               px.smp[l] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        px.pv = ($urandom_range(99) < 80);
        return px;
    endfunction

    initial begin : stimulus
        pixel_t px;
        int unsigned n_items;
        cfg_reg = '{32'd3, 32'd3, 32'd1024, 32'd8, 32'd1, 32'd65535};
        col_pos = 0;
        row_pos = 0;
        ring_head = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 3x3 over 4-pixel lines; lone small sample in a zero window
        // with zero eps gives a zero denominator and a saturated output, then
        // wholly invalid rows and a row of lane-wise extremes
        set_config(3, 3, 4, 8, 0, 16'h1234);
        for (int r = 0; r < 6; r++) begin
            for (int c = 0; c < 4; c++) begin
                for (int l = 0; l < NLANE; l++) begin
                    if (r < 3)       px.smp[l] = (r == 1 && c == 1) ? 16'd3 : 16'd0;
                    else if (r == 5) px.smp[l] = (l % 2 == 0) ? 16'hFFFF : 16'h0001;
                    else             px.smp[l] = 16'hFFFF;
                end
                px.pv = (r < 3) || (r == 5 && c % 2 == 1);
                pending_pixels.push_back(px);
            end
        end
        drain_block();

        // clamped extremes: width above limit, zero window, zero lanes, top eps
        set_config(0, 2, 2047, 0, 16'hFFFF, 0);
        for (int i = 0; i < 12; i++) pending_pixels.push_back(random_pixel());
        drain_block();

        // window wider than line: nothing comes out; writes past the map are ignored
        set_config(15, 15, 2, 15, 0, 16'hFFFF);
        reg_write(6, 32'h5);
        reg_write(7, 32'hFFFF_FFFF);
        for (int i = 0; i < 10; i++) pending_pixels.push_back(random_pixel());
        drain_block();

        for (int p = 0; p < 12; p++) begin
            send_idle_pct = (p < 4) ? 24 : (p < 8) ? 84 : 0;
            recv_idle_pct = (p < 4) ? 84 : (p < 8) ? 24 : 0;
            n_items = 130;
            if (p == 5) begin
                set_config(15, 15, 16, 8, $urandom_range(3), $urandom);
                n_items = 320;
            end else begin
                set_config($urandom_range(7), $urandom_range(7), $urandom_range(20, 1),
                           $urandom_range(15), $urandom_range(1) ? $urandom : 0, $urandom);
            end
            if (p == 2) long_hold_req = 1;
            for (int i = 0; i < n_items; i++) pending_pixels.push_back(random_pixel());
            drain_block();
        end

        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/mwcv_pkg.sv
sv/mwcv_ram.sv
sv/mwcv_div.sv
sv/mwcv_lane.sv
sv/mwcv_merge.sv
sv/masked_window_coefficient_of_variation.sv
sv/mwcv_checker.sv
bench/masked_window_coefficient_of_variation_tb.sv
